// ----- design/dedil_pkg.sv -----
// Shared constants, codes and control types for the double-ended indexed list.
`default_nettype none
package dedil_pkg;

	localparam int CAPACITY      = 256;
	localparam int ELEMENT_WIDTH = 32;
	localparam int IDX_W         = $clog2(CAPACITY);
	localparam int CNT_W         = IDX_W + 1;
	localparam int POS_W         = 8;
	localparam int OP_W          = 3;
	localparam int STATUS_W      = 2;

	typedef enum logic [OP_W-1:0] {
		OP_INS_HEAD = 3'd0,
		OP_INS_TAIL = 3'd1,
		OP_REM_HEAD = 3'd2,
		OP_REM_TAIL = 3'd3,
		OP_RD_HEAD  = 3'd4,
		OP_RD_TAIL  = 3'd5,
		OP_RD_INDEX = 3'd6,
		OP_NONE     = 3'd7
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2,
		ST_RANGE = 2'd3
	} status_t;

	// Per-cycle command broadcast to every cell
	typedef struct packed {
		logic shift_r;  // every cell takes its left neighbour (insert at head)
		logic shift_l;  // every cell takes its right neighbour (remove head)
		logic wr_tail;  // the selected cell loads the new element
		logic snap;     // read chain copies the element chain
		logic rd_step;  // read chain moves one cell towards the head
	} cell_ctrl_t;

endpackage
`default_nettype wire

// ----- design/dedil_cell.sv -----
// One list cell: an element register and a read-chain register.
`default_nettype none
module dedil_cell (
	input  wire logic                                clk,
	input  wire dedil_pkg::cell_ctrl_t               ctrl,
	input  wire logic                                wr_sel,
	input  wire logic [dedil_pkg::ELEMENT_WIDTH-1:0] wr_value,
	input  wire logic [dedil_pkg::ELEMENT_WIDTH-1:0] left_elem,
	input  wire logic [dedil_pkg::ELEMENT_WIDTH-1:0] right_elem,
	input  wire logic [dedil_pkg::ELEMENT_WIDTH-1:0] right_rd,
	output logic      [dedil_pkg::ELEMENT_WIDTH-1:0] elem,
	output logic      [dedil_pkg::ELEMENT_WIDTH-1:0] rd
);
	import dedil_pkg::*;

	logic [ELEMENT_WIDTH-1:0] elem_q;
	logic [ELEMENT_WIDTH-1:0] rd_q;

	always_ff @(posedge clk) begin
		if (ctrl.shift_r) begin
			elem_q <= left_elem;
		end else if (ctrl.shift_l) begin
			elem_q <= right_elem;
		end else if (ctrl.wr_tail && wr_sel) begin
			elem_q <= wr_value;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.snap) begin
			rd_q <= elem_q;
		end else if (ctrl.rd_step) begin
			rd_q <= right_rd;
		end
	end

	assign elem = elem_q;
	assign rd   = rd_q;

endmodule
`default_nettype wire

// ----- design/dedil_ctrl.sv -----
// Sequencer: element count, operation decode, read-chain timing and result register.
`default_nettype none
module dedil_ctrl (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_valid,
	output logic                                     in_ready,
	input  wire logic [dedil_pkg::OP_W-1:0]          op,
	input  wire logic [dedil_pkg::POS_W-1:0]         position,
	input  wire logic [dedil_pkg::ELEMENT_WIDTH-1:0] head_rd,
	output dedil_pkg::cell_ctrl_t                    cell_ctrl,
	output logic      [dedil_pkg::IDX_W-1:0]         tail_idx,
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output logic      [dedil_pkg::ELEMENT_WIDTH-1:0] read_data,
	output logic                                     read_valid,
	output logic      [dedil_pkg::CNT_W-1:0]         list_size,
	output logic      [dedil_pkg::STATUS_W-1:0]      status
);
	import dedil_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE  = 3'b001,
		S_SHIFT = 3'b010,
		S_DONE  = 3'b100
	} state_t;

	state_t                   state_q, state_d;
	logic [CNT_W-1:0]         count_q, count_d;
	logic [IDX_W-1:0]         left_q, left_d;
	logic                     out_valid_q;
	logic [ELEMENT_WIDTH-1:0] out_data_q;
	logic                     out_rv_q;
	logic [CNT_W-1:0]         out_size_q;
	status_t                  out_status_q;

	logic       accept;
	logic       out_free;
	logic       full, empty;
	logic       start_rd;
	logic [IDX_W-1:0] steps;
	status_t    st_d;
	logic       load_imm;
	logic       load_rd;

	assign out_free = !out_valid_q || out_ready;
	assign in_ready = (state_q == S_IDLE) && out_free;
	assign accept   = in_valid && in_ready;
	assign full     = (count_q == CNT_W'(CAPACITY));
	assign empty    = (count_q == '0);
	assign tail_idx = count_q[IDX_W-1:0];

	// Operation decode at accept
	always_comb begin
		cell_ctrl = '0;
		count_d   = count_q;
		start_rd  = 1'b0;
		steps     = '0;
		st_d      = ST_OK;
		if (accept) begin
			case (op_t'(op))
				OP_INS_HEAD: begin
					if (full) begin
						st_d = ST_FULL;
					end else begin
						cell_ctrl.shift_r = 1'b1;
						count_d = count_q + CNT_W'(1);
					end
				end
				OP_INS_TAIL: begin
					if (full) begin
						st_d = ST_FULL;
					end else begin
						cell_ctrl.wr_tail = 1'b1;
						count_d = count_q + CNT_W'(1);
					end
				end
				OP_REM_HEAD: begin
					if (empty) begin
						st_d = ST_EMPTY;
					end else begin
						cell_ctrl.shift_l = 1'b1;
						count_d = count_q - CNT_W'(1);
					end
				end
				OP_REM_TAIL: begin
					if (empty) begin
						st_d = ST_EMPTY;
					end else begin
						count_d = count_q - CNT_W'(1);
					end
				end
				OP_RD_HEAD: begin
					if (empty) begin
						st_d = ST_EMPTY;
					end else begin
						start_rd = 1'b1;
					end
				end
				OP_RD_TAIL: begin
					if (empty) begin
						st_d = ST_EMPTY;
					end else begin
						start_rd = 1'b1;
						steps    = IDX_W'(count_q - CNT_W'(1));
					end
				end
				OP_RD_INDEX: begin
					if (CNT_W'(position) >= count_q) begin
						st_d = ST_RANGE;
					end else begin
						start_rd = 1'b1;
						steps    = IDX_W'(position);
					end
				end
				default: begin
				end
			endcase
		end
		cell_ctrl.snap    = start_rd;
		cell_ctrl.rd_step = (state_q == S_SHIFT);
	end

	// Read sequencing
	always_comb begin
		state_d = state_q;
		left_d  = left_q;
		load_rd = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (start_rd) begin
					left_d  = steps;
					state_d = (steps == '0) ? S_DONE : S_SHIFT;
				end
			end
			S_SHIFT: begin
				left_d = left_q - IDX_W'(1);
				if (left_q == IDX_W'(1)) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (out_free) begin
					load_rd = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign load_imm = accept && !start_rd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			left_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			left_q  <= left_d;
			if (load_imm || load_rd) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_imm) begin
			out_data_q   <= '0;
			out_rv_q     <= 1'b0;
			out_size_q   <= count_d;
			out_status_q <= st_d;
		end else if (load_rd) begin
			out_data_q   <= head_rd;
			out_rv_q     <= 1'b1;
			out_size_q   <= count_q;
			out_status_q <= ST_OK;
		end
	end

	assign out_valid  = out_valid_q;
	assign read_data  = out_data_q;
	assign read_valid = out_rv_q;
	assign list_size  = out_size_q;
	assign status     = out_status_q;

endmodule
`default_nettype wire

// ----- design/double_ended_indexed_list_core.sv -----
// Top level of the double-ended indexed list: a row of element cells and its sequencer.
//
// Usage
//   Input channel s_*: one item per operation. s_tuser carries the operation code,
//   s_tdata the read position and the element to insert. Output channel m_*: exactly
//   one result item per operation, giving read data, a valid flag, the size after the
//   operation and a status code (ok, full, empty, index out of range).
//   The list is held as a row of cells with the head always in cell 0. Insert at head
//   shifts the whole row one cell towards the tail, remove head shifts it back, insert
//   at tail loads the cell just past the last element, remove tail only moves the count.
//   A read snapshots the row into a second chain of registers which then steps towards
//   cell 0 once per cycle, so the wanted element arrives at cell 0.
// Latency and throughput
//   Inserts, removes, rejected operations and unused codes: result registered one cycle
//   after acceptance, next item may be taken in the following cycle.
//   Read at position p (head p = 0, tail p = size - 1): result after p + 2 cycles; no new
//   item is taken until it has been loaded into the output register. The read chain
//   stepping speed of one cell per cycle sets this figure.
// Reset and stalls
//   arst_n empties the list (count zero, idle); cell contents are not cleared. While
//   m_tready is low the result is held in the output register and s_tready drops once a
//   further result would need that register.
`default_nettype none
module double_ended_indexed_list_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [39:0] s_tdata,   // [7:0] position, [39:8] element
	input  wire logic [2:0]  s_tuser,   // [2:0] op
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [47:0] m_tdata,   // [31:0] read_data, [40:32] list_size, [47:41] zero
	output logic      [2:0]  m_tuser    // [0] read_valid, [2:1] status
);
	import dedil_pkg::*;

	cell_ctrl_t               cell_ctrl;
	logic [IDX_W-1:0]         tail_idx;
	logic [ELEMENT_WIDTH-1:0] elem_w [CAPACITY];
	logic [ELEMENT_WIDTH-1:0] rd_w   [CAPACITY];
	logic [ELEMENT_WIDTH-1:0] element;
	logic [POS_W-1:0]         position;
	logic [ELEMENT_WIDTH-1:0] read_data;
	logic                     read_valid;
	logic [CNT_W-1:0]         list_size;
	logic [STATUS_W-1:0]      status;

	assign position = s_tdata[POS_W-1:0];
	assign element  = s_tdata[POS_W +: ELEMENT_WIDTH];

	dedil_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.op         (s_tuser),
		.position   (position),
		.head_rd    (rd_w[0]),
		.cell_ctrl  (cell_ctrl),
		.tail_idx   (tail_idx),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.read_data  (read_data),
		.read_valid (read_valid),
		.list_size  (list_size),
		.status     (status)
	);

	// Row of cells; cell 0 is the head, new head element enters from the left
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [ELEMENT_WIDTH-1:0] left_elem;
		logic [ELEMENT_WIDTH-1:0] right_elem;
		logic [ELEMENT_WIDTH-1:0] right_rd;
		logic                     wr_sel;

		if (i == 0) begin : g_first
			assign left_elem = element;
		end else begin : g_mid_l
			assign left_elem = elem_w[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign right_elem = elem_w[i];
			assign right_rd   = '0;
		end else begin : g_mid_r
			assign right_elem = elem_w[i+1];
			assign right_rd   = rd_w[i+1];
		end

		assign wr_sel = (tail_idx == IDX_W'(i));

		dedil_cell u_cell (
			.clk        (clk),
			.ctrl       (cell_ctrl),
			.wr_sel     (wr_sel),
			.wr_value   (element),
			.left_elem  (left_elem),
			.right_elem (right_elem),
			.right_rd   (right_rd),
			.elem       (elem_w[i]),
			.rd         (rd_w[i])
		);
	end

	assign m_tdata = {7'b0, list_size, read_data};
	assign m_tuser = {status, read_valid};

endmodule
`default_nettype wire
